// ----- design/spf_pkg.sv -----
// shared types and constants for the serial packet framer
package spf_pkg;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic [7:0] SYNC_FIRST     = 8'hAA;
  localparam logic [7:0] SYNC_SECOND    = 8'h55;
  localparam logic [7:0] FRAME_OVERHEAD = 8'd5;

  localparam int BURST_MAX = 5;
  localparam int BURST_W   = 3;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BURST_W-1:0]        count;
    logic                      closes;
  } burst_t;

endpackage

// ----- design/serial_packet_framer_sum8.sv -----
// serial packet framer with 8-bit additive checksum
//
// input channel s_axis: one beat is a command. tuser = 0 starts a frame with
// payload_length and frame_number from tdata; tuser = 1 carries one payload
// byte. a start turns into four header beats (0xAA, 0x55, length + 5, frame
// number), plus the checksum at once for an empty payload. each payload beat
// inside a frame gives its byte, and the last one is followed by the
// checksum. oversized starts and payload beats outside a frame give nothing.
// output channel m_axis: one frame byte per beat, tlast on the checksum.
// an accepted beat is registered into a burst slot (pend), and from there into
// the output stage (act) that drives m_axis. a burst goes out one byte per
// output beat, and a new beat is taken whenever the slot is free or is handing
// its burst on, so payload beats stream at one per cycle while m_axis is ready,
// and the four or five bytes of a start hold back the beats behind it.
// when m_axis stalls, the current burst holds and one more burst waits in the
// slot, after which s_axis_tready drops.
// reset clears the frame state and both burst stages; no beat is lost or
// repeated by stalls on either side.
module serial_packet_framer_sum8
  import spf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // payload_length, frame_number, payload_byte
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // tx_byte
  output logic        m_axis_tlast   // frame_end
);

  localparam int LEFT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic              in_frame, in_frame_next;
  logic [LEFT_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]        running_sum, running_sum_next;

  logic   pend_valid;
  burst_t pend;
  burst_t burst_next;
  logic   act_valid;
  burst_t act;
  logic [BURST_W-1:0] pos;

  logic [7:0] len, num, data;
  logic [7:0] hdr_len, hdr_sum, pay_sum;
  logic       in_fire, act_last, act_take, act_load;

  assign len  = s_axis_tdata[7:0];
  assign num  = s_axis_tdata[15:8];
  assign data = s_axis_tdata[23:16];

  assign s_axis_tready = !pend_valid || act_load;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign hdr_len = len + FRAME_OVERHEAD;
  assign hdr_sum = SYNC_FIRST + SYNC_SECOND + hdr_len + num;
  assign pay_sum = running_sum + data;

  always_comb begin
    in_frame_next    = in_frame;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    burst_next       = '0;
    if (s_axis_tuser == CMD_START) begin
      if (len <= MAX_LEN) begin
        burst_next.bytes[0] = SYNC_FIRST;
        burst_next.bytes[1] = SYNC_SECOND;
        burst_next.bytes[2] = hdr_len;
        burst_next.bytes[3] = num;
        if (len == 8'd0) begin
          burst_next.bytes[4] = hdr_sum;
          burst_next.count    = BURST_W'(5);
          burst_next.closes   = 1'b1;
          in_frame_next       = 1'b0;
          bytes_left_next     = '0;
          running_sum_next    = '0;
        end else begin
          burst_next.count = BURST_W'(4);
          in_frame_next    = 1'b1;
          bytes_left_next  = len[LEFT_W-1:0];
          running_sum_next = hdr_sum;
        end
      end
    end else if (in_frame && bytes_left != '0) begin
      burst_next.bytes[0] = data;
      if (bytes_left == LEFT_W'(1)) begin
        burst_next.bytes[1] = pay_sum;
        burst_next.count    = BURST_W'(2);
        burst_next.closes   = 1'b1;
        in_frame_next       = 1'b0;
        bytes_left_next     = '0;
        running_sum_next    = '0;
      end else begin
        burst_next.count = BURST_W'(1);
        bytes_left_next  = bytes_left - LEFT_W'(1);
        running_sum_next = pay_sum;
      end
    end
  end

  assign act_last = (pos == act.count - BURST_W'(1));
  assign act_take = act_valid && m_axis_tready;
  assign act_load = !act_valid || (act_take && act_last);

  assign m_axis_tvalid = act_valid;
  assign m_axis_tdata  = act.bytes[pos];
  assign m_axis_tlast  = act.closes && act_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_left  <= '0;
      running_sum <= '0;
      pend_valid  <= 1'b0;
      act_valid   <= 1'b0;
      pos         <= '0;
    end else begin
      if (in_fire) begin
        in_frame    <= in_frame_next;
        bytes_left  <= bytes_left_next;
        running_sum <= running_sum_next;
      end
      if (in_fire && burst_next.count != '0) begin
        pend_valid <= 1'b1;
        pend       <= burst_next;
      end else if (act_load) begin
        pend_valid <= 1'b0;
      end
      if (act_load) begin
        act_valid <= pend_valid;
        pos       <= '0;
        if (pend_valid) begin
          act <= pend;
        end
      end else if (act_take) begin
        pos <= pos + BURST_W'(1);
      end
    end
  end

endmodule

// ----- design/spf_checker.sv -----
// port-level checks for the serial packet framer, bound to the top level
module spf_checker
  import spf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // reset leaves both burst stages empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("framer not empty after reset");

  // an accepted in-range start is followed by a valid output beat
  a_start_fills: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_START &&
     s_axis_tdata[7:0] <= MAX_LEN) |-> ##2 m_axis_tvalid)
    else $error("start beat produced no header burst");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output beat changed while stalled");

endmodule

bind serial_packet_framer_sum8 spf_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_spf_checker (.*);

// ----- verif/serial_packet_framer_sum8_tb.sv -----
// testbench for the serial packet framer with 8-bit additive checksum
module serial_packet_framer_sum8_tb;
  import spf_pkg::*;

  localparam int FRAME_MAX = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // payload_length, frame_number, payload_byte
  logic        s_axis_tuser;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // tx_byte
  logic        m_axis_tlast;  // frame_end

  frame_beat_t frame_bytes_q[$];
  logic        open_frame;
  logic [7:0]  remaining;
  logic [7:0]  checksum_acc;

  int errors;
  int useful_beats;
  int src_idle;
  int dst_idle;
  int hold_req;
  int hold_left;

  serial_packet_framer_sum8 #(
    .MAX_PAYLOAD(FRAME_MAX)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void queue_frame_byte(logic [7:0] b, logic last);
    frame_bytes_q.push_back('{data: b, last: last});
    if (!last) begin
      checksum_acc = checksum_acc + b;
    end
  endfunction

  function automatic int predict_frame_bytes(logic cmd, logic [7:0] len, logic [7:0] num,
                                             logic [7:0] data);
    if (cmd == CMD_START) begin
      if (len > FRAME_MAX) begin
        return 0;
      end
      checksum_acc = 8'd0;
      queue_frame_byte(SYNC_FIRST, 1'b0);
      queue_frame_byte(SYNC_SECOND, 1'b0);
      queue_frame_byte(len + FRAME_OVERHEAD, 1'b0);
      queue_frame_byte(num, 1'b0);
      if (len == 8'd0) begin
        queue_frame_byte(checksum_acc, 1'b1);
        open_frame = 1'b0;
        remaining = 8'd0;
        checksum_acc = 8'd0;
        return 5;
      end
      open_frame = 1'b1;
      remaining = len;
      return 4;
    end
    if (!open_frame || remaining == 8'd0) begin
      return 0;
    end
    queue_frame_byte(data, 1'b0);
    remaining = remaining - 8'd1;
    if (remaining == 8'd0) begin
      queue_frame_byte(checksum_acc, 1'b1);
      open_frame = 1'b0;
      checksum_acc = 8'd0;
      return 2;
    end
    return 1;
  endfunction

  task automatic send_beat(logic cmd, logic [7:0] len, logic [7:0] num, logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, num, len};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    if (predict_frame_bytes(cmd, len, num, data) > 0) begin
      useful_beats++;
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver ready at random, with a long hold-off when a test requests one
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data %02h last %0b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = frame_bytes_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          report_mismatch($sformatf("tdata %02h, expected %02h", m_axis_tdata, want.data));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("tlast %0b, expected %0b on byte %02h",
                                    m_axis_tlast, want.last, want.data));
        end
      end
    end
  end

  task automatic test_directed();
    send_beat(CMD_START, 8'd0, 8'h00, 8'h00);
    send_beat(CMD_START, 8'd0, 8'hFF, 8'hFF);
    send_beat(CMD_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_START, 8'd1, 8'h80, 8'h00);
    send_beat(CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    send_beat(CMD_START, 8'd33, 8'h01, 8'h00);
    send_beat(CMD_START, 8'd255, 8'h02, 8'h00);
    // new start abandons an unfinished frame
    send_beat(CMD_START, 8'd3, 8'h07, 8'h00);
    send_beat(CMD_PAYLOAD, 8'd0, 8'd0, 8'h00);
    send_beat(CMD_PAYLOAD, 8'd0, 8'd0, 8'h01);
    send_beat(CMD_START, 8'd2, 8'h08, 8'h00);
    send_beat(CMD_PAYLOAD, 8'd0, 8'd0, 8'h12);
    // oversized start inside a frame leaves it running
    send_beat(CMD_START, 8'd40, 8'h09, 8'h00);
    send_beat(CMD_PAYLOAD, 8'd0, 8'd0, 8'h34);
    send_beat(CMD_PAYLOAD, 8'd0, 8'd0, 8'h00);
    // checksum wraps around
    send_beat(CMD_START, 8'd2, 8'hFF, 8'hFF);
    send_beat(CMD_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    hold_req = 150;
    send_beat(CMD_START, 8'(FRAME_MAX), 8'($urandom), 8'($urandom));
    for (int i = 0; i < FRAME_MAX; i++) begin
      send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_pause_mid_frame();
    send_beat(CMD_START, 8'd4, 8'h5A, 8'($urandom));
    send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    stop_sending();
    wait_drained();
    send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random(int n_beats);
    int goal;
    int r;
    int len;
    int n_pay;
    goal = useful_beats + n_beats;
    while (useful_beats < goal) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_beat(CMD_START, 8'($urandom_range(255, FRAME_MAX + 1)), 8'($urandom),
                  8'($urandom));
      end else if (r < 14 && !open_frame) begin
        send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          len = $urandom_range(8);
        end else if (r < 88) begin
          len = $urandom_range(FRAME_MAX);
        end else begin
          len = FRAME_MAX;
        end
        n_pay = len;
        if (len > 0 && $urandom_range(99) < 8) begin
          n_pay = $urandom_range(len - 1);
        end
        send_beat(CMD_START, 8'(len), 8'($urandom), 8'($urandom));
        for (int i = 0; i < n_pay; i++) begin
          if ($urandom_range(99) < 4) begin
            send_beat(CMD_START, 8'($urandom_range(255, FRAME_MAX + 1)), 8'($urandom),
                      8'($urandom));
          end
          send_beat(CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    stop_sending();
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 24'd0;
    s_axis_tuser = CMD_START;
    m_axis_tready = 1'b0;
    open_frame = 1'b0;
    remaining = 8'd0;
    checksum_acc = 8'd0;
    errors = 0;
    useful_beats = 0;
    hold_req = 0;
    hold_left = 0;
    src_idle = 28;
    dst_idle = 67;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(60);

    src_idle = 67;
    dst_idle = 28;
    test_pause_mid_frame();
    test_random(60);

    src_idle = 0;
    dst_idle = 0;
    test_output_holdoff();
    test_random(60);

    repeat (10) @(posedge clk);
    if (frame_bytes_q.size() != 0) begin
      report_mismatch($sformatf("%0d frame bytes never arrived", frame_bytes_q.size()));
    end
    if (errors == 0) begin
      $display("** serial_packet_framer_sum8: PASSED **");
    end else begin
      $display("** serial_packet_framer_sum8: FAILED **");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d frame bytes outstanding", frame_bytes_q.size());
    $display("** serial_packet_framer_sum8: FAILED **");
    $finish;
  end

endmodule
